/* rtl/core/psrac_pkg.sv */
// ----------------------------------------------------------------------------
// psrac_pkg: shared types and constants
// Widths, register codes, rotation micro-ops and the output saturation helper
// for the point set rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package psrac_pkg;

  localparam int unsigned COORD_W   = 24;  // Q15.8 coordinate
  localparam int unsigned COEF_W    = 16;  // Q1.14 cosine / sine
  localparam int unsigned SUM_W     = COORD_W + 1;  // min + max, Q.9 centre
  localparam int unsigned VAL_W     = 34;  // working value, Q.9, covers 3 stages
  localparam int unsigned PROD_W    = VAL_W + COEF_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned RND_SH    = 14;
  localparam int unsigned RND_HALF  = 8192;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CFG   = 6;
  localparam int unsigned STORE_W   = 3 * COORD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_X = 3'd0,
    CFG_SIN_X = 3'd1,
    CFG_COS_Y = 3'd2,
    CFG_SIN_Y = 3'd3,
    CFG_COS_Z = 3'd4,
    CFG_SIN_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OPD_X,
    OPD_Y,
    OPD_Z
  } opd_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_e;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_T0,
    WB_PAIR
  } wb_e;

  typedef enum logic [1:0] {
    DST_YZ,
    DST_XZ,
    DST_XY
  } dst_e;

  typedef struct packed {
    opd_e     opd;
    cfg_idx_e coef;
    acc_e     acc;
    wb_e      wb;
    dst_e     dst;
  } rot_op_t;

  typedef struct packed {
    logic    take;       // input beat accepted
    logic    rd_clear;   // restart read index
    logic    sum_en;     // latch min + max
    logic    center_en;  // load centred point from store
    logic    rot_en;     // run one rotation micro-op
    rot_op_t op;
    logic    fin_en;     // register the result beat
    logic    rd_next;    // advance read index
    logic    run_done;   // empty the store
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

  // One rotation stage is six phases: four products, two write-backs.
  function automatic rot_op_t rot_op(logic [1:0] stage, logic [2:0] phase);
    opd_e     o0, o1, o2, o3;
    cfg_idx_e k0, k1, k2, k3;
    acc_e     a1, a3;
    dst_e     d;
    rot_op_t  r;
    o0 = OPD_X; o1 = OPD_X; o2 = OPD_X; o3 = OPD_X;
    k0 = CFG_COS_X; k1 = CFG_COS_X; k2 = CFG_COS_X; k3 = CFG_COS_X;
    a1 = ACC_HOLD; a3 = ACC_HOLD; d = DST_YZ;
    unique case (stage)
      2'd0: begin
        o0 = OPD_Y; k0 = CFG_COS_X; o1 = OPD_Z; k1 = CFG_SIN_X; a1 = ACC_SUB;
        o2 = OPD_Y; k2 = CFG_SIN_X; o3 = OPD_Z; k3 = CFG_COS_X; a3 = ACC_ADD;
        d  = DST_YZ;
      end
      2'd1: begin
        o0 = OPD_X; k0 = CFG_COS_Y; o1 = OPD_Z; k1 = CFG_SIN_Y; a1 = ACC_ADD;
        o2 = OPD_Z; k2 = CFG_COS_Y; o3 = OPD_X; k3 = CFG_SIN_Y; a3 = ACC_SUB;
        d  = DST_XZ;
      end
      2'd2: begin
        o0 = OPD_X; k0 = CFG_COS_Z; o1 = OPD_Y; k1 = CFG_SIN_Z; a1 = ACC_SUB;
        o2 = OPD_X; k2 = CFG_SIN_Z; o3 = OPD_Y; k3 = CFG_COS_Z; a3 = ACC_ADD;
        d  = DST_XY;
      end
      default: begin
      end
    endcase
    r.dst = d;
    r.opd = o0; r.coef = k0; r.acc = ACC_HOLD; r.wb = WB_NONE;
    unique case (phase)
      3'd0: begin r.opd = o0; r.coef = k0; end
      3'd1: begin r.opd = o1; r.coef = k1; r.acc = ACC_LOAD; end
      3'd2: begin r.opd = o2; r.coef = k2; r.acc = a1; end
      3'd3: begin r.opd = o3; r.coef = k3; r.acc = ACC_LOAD; r.wb = WB_T0; end
      3'd4: begin r.acc = a3; end
      3'd5: begin r.wb = WB_PAIR; end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Move back by the centre, halve with round half up, clamp to Q15.8.
  function automatic logic [COORD_W-1:0] sat_out(logic signed [VAL_W-1:0] v,
                                                 logic signed [SUM_W-1:0] s);
    logic signed [VAL_W:0] t;
    logic signed [VAL_W:0] h;
    logic signed [VAL_W:0] hi;
    logic signed [VAL_W:0] lo;
    hi = (VAL_W+1)'(8388607);
    lo = -(VAL_W+1)'(8388608);
    t  = (VAL_W+1)'(v) + (VAL_W+1)'(s) + (VAL_W+1)'(1);
    h  = t >>> 1;
    if (h > hi) begin
      return hi[COORD_W-1:0];
    end else if (h < lo) begin
      return lo[COORD_W-1:0];
    end
    return h[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/point_set_rotate_about_center_unit.sv */
// ----------------------------------------------------------------------------
// point_set_rotate_about_center_unit: rotate a point set about its box centre
// Gathers points, then emits each one centred, rotated about X, Y and Z and
// moved back, saturated to Q15.8.
// ----------------------------------------------------------------------------
//
//   channel | handshake                 | payload
//   --------+---------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o   | px_i py_i pz_i final_point_i
//   out     | out_valid_o / out_stall_i | rx_o ry_o rz_o end_of_run_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i cfg_data_i
//
// Cycles: one input beat a cycle while gathering. A beat marked final starts
// the run; each result then goes through fetch, centre, three stages of six
// micro-ops on the one shared multiplier, the output register and the offer,
// which waits out any stall on the output. Inputs are held off until the last
// result is taken. Reset: coefficients return to identity, the store is empty;
// no clearing pass is needed. The config port is always ready.
//
`default_nettype none

module point_set_rotate_about_center_unit #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [psrac_pkg::COORD_W-1:0]    px_i,
  input  wire logic [psrac_pkg::COORD_W-1:0]    py_i,
  input  wire logic [psrac_pkg::COORD_W-1:0]    pz_i,
  input  wire logic                             final_point_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [psrac_pkg::COORD_W-1:0]    rx_o,
  output logic      [psrac_pkg::COORD_W-1:0]    ry_o,
  output logic      [psrac_pkg::COORD_W-1:0]    rz_o,
  output logic                                  end_of_run_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [psrac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [psrac_pkg::COEF_W-1:0]     cfg_data_i
);
  import psrac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  psrac_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .final_point_i (final_point_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  psrac_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .px_i         (px_i),
    .py_i         (py_i),
    .pz_i         (pz_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .rx_o         (rx_o),
    .ry_o         (ry_o),
    .rz_o         (rz_o),
    .end_of_run_o (end_of_run_o)
  );

  // No input beat is taken while a result is offered
  a_no_in_during_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while result pending");

  // A final beat closes the input side for the run
  a_final_holds_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && final_point_i) |=> (in_stall_o && !out_valid_o))
    else $error("input side open after final beat");

  // Taking the last result of a run reopens the input side
  a_run_end_reopens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && end_of_run_o) |=> (!in_stall_o && !out_valid_o))
    else $error("run did not end after last result");

endmodule

`default_nettype wire

/* rtl/core/psrac_ram.sv */
// ----------------------------------------------------------------------------
// psrac_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psrac_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/psrac_dp.sv */
// ----------------------------------------------------------------------------
// psrac_dp: datapath
// Point store, bounding box, coefficient registers, shared multiplier with
// accumulator, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psrac_dp #(
  parameter int unsigned MAX_POINTS = 64,
  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1),
  localparam int unsigned IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire psrac_pkg::dp_cmd_t                   cmd_i,
  output psrac_pkg::dp_stat_t                       stat_o,
  input  wire logic [psrac_pkg::COORD_W-1:0]        px_i,
  input  wire logic [psrac_pkg::COORD_W-1:0]        py_i,
  input  wire logic [psrac_pkg::COORD_W-1:0]        pz_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [psrac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [psrac_pkg::COEF_W-1:0]         cfg_data_i,
  output logic      [psrac_pkg::COORD_W-1:0]        rx_o,
  output logic      [psrac_pkg::COORD_W-1:0]        ry_o,
  output logic      [psrac_pkg::COORD_W-1:0]        rz_o,
  output logic                                      end_of_run_o
);
  import psrac_pkg::*;

  logic [CNT_W-1:0] count_q, rd_idx_q;
  logic             full;
  logic             store_we;
  logic [STORE_W-1:0] rdata;

  logic signed [COORD_W-1:0] pin [3];
  logic signed [COORD_W-1:0] pst [3];
  logic signed [COORD_W-1:0] min_q [3];
  logic signed [COORD_W-1:0] max_q [3];
  logic signed [SUM_W-1:0]   sum_q [3];
  logic signed [COEF_W-1:0]  coef_q [NUM_CFG];

  logic signed [VAL_W-1:0]  x_q, y_q, z_q, t0_q, opd_v, rnd_v;
  logic signed [COEF_W-1:0] coef_v;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, acc_r;

  assign pin[0] = px_i;
  assign pin[1] = py_i;
  assign pin[2] = pz_i;
  assign pst[0] = rdata[STORE_W-1:2*COORD_W];
  assign pst[1] = rdata[2*COORD_W-1:COORD_W];
  assign pst[2] = rdata[COORD_W-1:0];

  assign full     = (count_q == CNT_W'(MAX_POINTS));
  assign store_we = cmd_i.take && !full;
  assign stat_o.last = (CNT_W'(rd_idx_q + 1'b1) == count_q);

  psrac_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({px_i, py_i, pz_i}),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Fill count and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.run_done) begin
        count_q <= '0;
      end else if (store_we) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.rd_clear) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_next) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[CFG_COS_X] <= COEF_W'(16384);
      coef_q[CFG_SIN_X] <= '0;
      coef_q[CFG_COS_Y] <= COEF_W'(16384);
      coef_q[CFG_SIN_Y] <= '0;
      coef_q[CFG_COS_Z] <= COEF_W'(16384);
      coef_q[CFG_SIN_Z] <= '0;
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_CFG))) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Bounding box and centre
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (store_we) begin
        if (count_q == '0 || pin[a] < min_q[a]) min_q[a] <= pin[a];
        if (count_q == '0 || pin[a] > max_q[a]) max_q[a] <= pin[a];
      end
      if (cmd_i.sum_en) begin
        sum_q[a] <= SUM_W'(min_q[a]) + SUM_W'(max_q[a]);
      end
    end
  end

  // Shared multiplier and accumulator
  always_comb begin
    unique case (cmd_i.op.opd)
      OPD_X:   opd_v = x_q;
      OPD_Y:   opd_v = y_q;
      default: opd_v = z_q;
    endcase
    coef_v = coef_q[cmd_i.op.coef];
    unique case (cmd_i.op.acc)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      ACC_SUB:  acc_d = acc_q - ACC_W'(prod_q);
      default:  acc_d = acc_q;
    endcase
    acc_r = acc_q + ACC_W'(RND_HALF);
    rnd_v = acc_r[RND_SH+VAL_W-1:RND_SH];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opd_v * coef_v;
    if (cmd_i.center_en) begin
      x_q <= (VAL_W'(pst[0]) <<< 1) - VAL_W'(sum_q[0]);
      y_q <= (VAL_W'(pst[1]) <<< 1) - VAL_W'(sum_q[1]);
      z_q <= (VAL_W'(pst[2]) <<< 1) - VAL_W'(sum_q[2]);
    end else if (cmd_i.rot_en && cmd_i.op.wb == WB_PAIR) begin
      unique case (cmd_i.op.dst)
        DST_YZ: begin y_q <= t0_q; z_q <= rnd_v; end
        DST_XZ: begin x_q <= t0_q; z_q <= rnd_v; end
        default: begin x_q <= t0_q; y_q <= rnd_v; end
      endcase
    end
    if (cmd_i.rot_en) begin
      acc_q <= acc_d;
      if (cmd_i.op.wb == WB_T0) begin
        t0_q <= rnd_v;
      end
    end
    if (cmd_i.fin_en) begin
      rx_o         <= sat_out(x_q, sum_q[0]);
      ry_o         <= sat_out(y_q, sum_q[1]);
      rz_o         <= sat_out(z_q, sum_q[2]);
      end_of_run_o <= stat_o.last;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/psrac_ctrl.sv */
// ----------------------------------------------------------------------------
// psrac_ctrl: controller
// Sequences loading, fetch, centring, the rotation micro-ops and output.
// ----------------------------------------------------------------------------
`default_nettype none

module psrac_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 final_point_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire psrac_pkg::dp_stat_t  stat_i,
  output psrac_pkg::dp_cmd_t        cmd_o
);
  import psrac_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FETCH  = 6'b000010,
    ST_CENTER = 6'b000100,
    ST_ROT    = 6'b001000,
    ST_FIN    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] stage_q, stage_d;
  logic [2:0] phase_q, phase_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.op = rot_op(stage_q, phase_q);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && final_point_i) begin
          cmd_o.rd_clear = 1'b1;
          state_d        = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_CENTER;
      end
      ST_CENTER: begin
        cmd_o.center_en = 1'b1;
        stage_d         = '0;
        phase_d         = '0;
        state_d         = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.rot_en = 1'b1;
        if (phase_q == 3'd5) begin
          phase_d = '0;
          stage_d = stage_q + 1'b1;
          if (stage_q == 2'd2) begin
            state_d = ST_FIN;
          end
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.last) begin
            cmd_o.run_done = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_point_set_rotate_about_center_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_set_rotate_about_center_unit: self-checking bench for the rotator
// Point sets are streamed in, mostly with random gaps. A local Q-format
// predictor tracks the box, the centre and the three rotations. Every result
// beat is checked in order against the predicted points and end-of-run flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_set_rotate_about_center_unit;
  import psrac_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam longint      SAT_HI      = 64'sd8388607;
  localparam longint      SAT_LO      = -64'sd8388608;

  typedef struct {
    logic [COORD_W-1:0] x, y, z;
    logic               fin;
  } point_beat_t;

  typedef struct {
    logic [COORD_W-1:0] x, y, z;
    logic               eor;
  } rot_beat_t;

  logic clk_i, rst_ni;
  logic in_valid, in_stall;
  logic [COORD_W-1:0] px, py, pz;
  logic final_pt;
  logic out_valid, out_stall;
  logic [COORD_W-1:0] rx, ry, rz;
  logic eor;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  point_beat_t point_queue[$];
  rot_beat_t   rotated_queue[$];

  // Bench copy of block state
  logic signed [COEF_W-1:0]  coef[NUM_CFG];
  logic signed [COORD_W-1:0] pts[STORE_DEPTH][3];
  logic signed [COORD_W-1:0] box_min[3], box_max[3];
  int unsigned               n_pts;

  logic [COEF_W-1:0] coef_plan[8];
  bit   in_gaps, out_gaps;
  int   errors;
  int unsigned quiet_cycles;

  point_set_rotate_about_center_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .px_i         (px),
    .py_i         (py),
    .pz_i         (pz),
    .final_point_i(final_pt),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .rx_o         (rx),
    .ry_o         (ry),
    .rz_o         (rz),
    .end_of_run_o (eor),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Round a Q.23 product sum back to Q.9, half up
  function automatic longint round14(longint v);
    return (v + longint'(RND_HALF)) >>> RND_SH;
  endfunction

  // Gather one beat; on the final mark, rotate the whole set about its centre
  function automatic void gather_and_rotate(point_beat_t b);
    logic signed [COORD_W-1:0] p[3];
    longint ctr[3], v[3], t0, t1, r;
    longint c[NUM_CFG];
    rot_beat_t o;
    p[0] = b.x; p[1] = b.y; p[2] = b.z;
    // Drop points once the store is full; the final mark still counts
    if (n_pts < STORE_DEPTH) begin
      for (int a = 0; a < 3; a++) begin
        pts[n_pts][a] = p[a];
        if (n_pts == 0 || p[a] < box_min[a]) box_min[a] = p[a];
        if (n_pts == 0 || p[a] > box_max[a]) box_max[a] = p[a];
      end
      n_pts++;
    end
    if (!b.fin) return;
    for (int i = 0; i < NUM_CFG; i++) c[i] = coef[i];
    for (int a = 0; a < 3; a++) ctr[a] = longint'(box_min[a]) + longint'(box_max[a]);
    for (int k = 0; k < n_pts; k++) begin
      for (int a = 0; a < 3; a++) v[a] = 2 * longint'(pts[k][a]) - ctr[a];
      t0 = round14(v[1] * c[CFG_COS_X] - v[2] * c[CFG_SIN_X]);
      t1 = round14(v[1] * c[CFG_SIN_X] + v[2] * c[CFG_COS_X]);
      v[1] = t0; v[2] = t1;
      t0 = round14(v[0] * c[CFG_COS_Y] + v[2] * c[CFG_SIN_Y]);
      t1 = round14(v[2] * c[CFG_COS_Y] - v[0] * c[CFG_SIN_Y]);
      v[0] = t0; v[2] = t1;
      t0 = round14(v[0] * c[CFG_COS_Z] - v[1] * c[CFG_SIN_Z]);
      t1 = round14(v[0] * c[CFG_SIN_Z] + v[1] * c[CFG_COS_Z]);
      v[0] = t0; v[1] = t1;
      for (int a = 0; a < 3; a++) begin
        r = (v[a] + ctr[a] + 1) >>> 1;
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        v[a] = r;
      end
      o.x = v[0][COORD_W-1:0]; o.y = v[1][COORD_W-1:0]; o.z = v[2][COORD_W-1:0];
      o.eor = (k + 1 == n_pts);
      rotated_queue.push_back(o);
    end
    n_pts = 0;
  endfunction

  // Input driver: hold the beat while stalled, otherwise advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      px <= '0; py <= '0; pz <= '0; final_pt <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (point_queue.size() > 0 && !(in_gaps && $urandom_range(99) < 20)) begin
        in_valid <= 1'b1;
        px <= point_queue[0].x; py <= point_queue[0].y;
        pz <= point_queue[0].z; final_pt <= point_queue[0].fin;
        void'(point_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= out_gaps && ($urandom_range(99) < 20);
    end
  end

  // Monitor: predict on input beats, check result beats, watch for a hang
  always @(posedge clk_i) begin
    point_beat_t b;
    rot_beat_t   e;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        b.x = px; b.y = py; b.z = pz; b.fin = final_pt;
        gather_and_rotate(b);
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_CFG) coef[cfg_index] = cfg_data;
      if (out_valid && !out_stall) begin
        if (rotated_queue.size() == 0) begin
          $display("%0t: unexpected result beat x=%h y=%h z=%h eor=%b",
                   $time, rx, ry, rz, eor);
          errors++;
        end else begin
          e = rotated_queue.pop_front();
          if (rx !== e.x) begin
            $display("%0t: rx expected %h actual %h", $time, e.x, rx); errors++;
          end
          if (ry !== e.y) begin
            $display("%0t: ry expected %h actual %h", $time, e.y, ry); errors++;
          end
          if (rz !== e.z) begin
            $display("%0t: rz expected %h actual %h", $time, e.z, rz); errors++;
          end
          if (eor !== e.eor) begin
            $display("%0t: end_of_run expected %b actual %b", $time, e.eor, eor);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Write all eight config indexes from coef_plan; 6 and 7 must be ignored
  task automatic write_coefs();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= coef_plan[i];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Hold off until the block has drained every beat
  task automatic drain();
    while (point_queue.size() > 0 || in_valid || rotated_queue.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic queue_point(logic [COORD_W-1:0] x, y, z, logic fin);
    point_beat_t b;
    b.x = x; b.y = y; b.z = z; b.fin = fin;
    point_queue.push_back(b);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3:    return COORD_W'($signed($urandom_range(4095)) - 2048);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return 16'sd16384;
      1:       return -16'sd16384;
      2:       return COEF_W'($urandom);
      default: return COEF_W'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  initial begin
    int unsigned sz;
    errors = 0; quiet_cycles = 0;
    in_gaps = 1'b1; out_gaps = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    for (int i = 0; i < NUM_CFG; i++) coef[i] = (i % 2 == 0) ? 16'sd16384 : 16'sd0;
    n_pts = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity coefficients from reset: extremes, then a lone point
    queue_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
    queue_point(24'h800000, 24'h7FFFFF, 24'h000000, 1'b1);
    queue_point(24'h123456, 24'hFEDCBA, 24'h000001, 1'b1);
    drain();

    // Full-scale negative cosine and positive sine: saturation on the corners
    coef_plan = '{16'hC000, 16'h4000, 16'hC000, 16'h4000, 16'hC000, 16'h4000,
                  16'h1234, 16'hFFFF};
    write_coefs();
    queue_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    queue_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
    queue_point(24'h000000, 24'h7FFFFF, 24'h800000, 1'b1);
    // Overfill the store: the last points are dropped, the final mark still runs
    for (int i = 0; i < 70; i++)
      queue_point(rand_coord(), rand_coord(), rand_coord(), i == 69);
    drain();

    // Coefficients beyond +/-1.0, out to the Q1.14 extremes, are used as given
    coef_plan = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                  16'h0000, 16'h0000};
    write_coefs();
    queue_point(24'h000100, 24'hFFFF00, 24'h000080, 1'b0);
    queue_point(24'hFFFF80, 24'h000180, 24'h7FFFFF, 1'b1);
    queue_point(24'h000003, 24'h000001, 24'hFFFFFF, 1'b1);
    drain();

    // Random phases of small sets; one phase with no idling at all
    for (int ph = 0; ph < 8; ph++) begin
      in_gaps  = (ph != 3);
      out_gaps = (ph != 3);
      for (int i = 0; i < 8; i++) coef_plan[i] = rand_coef();
      write_coefs();
      for (int n = 0; n < 14; n += sz) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        for (int i = 0; i < sz; i++)
          queue_point(rand_coord(), rand_coord(), rand_coord(), i == sz - 1);
      end
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
